@@ design/countdown_timer_bank_defines.svh @@
// Assertion macros for the countdown timer bank.
`ifndef COUNTDOWN_TIMER_BANK_DEFINES_SVH
`define COUNTDOWN_TIMER_BANK_DEFINES_SVH

`ifndef SYNTH

// Checked on every clock edge outside reset.
`define CTB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("countdown_timer_bank assertion failed");

// Checked on every clock edge, reset included.
`define CTB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("countdown_timer_bank assertion failed");

`else

`define CTB_ASSERT(lbl, clk, rst_n, prop)
`define CTB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ design/ctb_pkg.sv @@
// Shared constants and types for the countdown timer bank.
`default_nettype none

package ctb_pkg;

  localparam int NumTimers  = 16;
  localparam int CountWidth = 16;
  localparam int IdxW       = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int TotW       = $clog2(NumTimers + 1);
  localparam int MaskW      = 16;
  localparam int CmdW       = 3;
  localparam int StatW      = 2;
  localparam int TidxW      = 4;
  localparam int RemW       = 16;

  typedef enum logic [CmdW-1:0] {
    CmdTick      = 3'd0,
    CmdAlloc     = 3'd1,
    CmdFree      = 3'd2,
    CmdStart     = 3'd3,
    CmdStop      = 3'd4,
    CmdLoadStart = 3'd5,
    CmdClrTmout  = 3'd6,
    CmdRead      = 3'd7
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StatOk     = 2'd0,
    StatBadIdx = 2'd1,
    StatNoFree = 2'd2,
    StatRsvd   = 2'd3
  } stat_e;

  typedef struct packed {
    logic auto_mode;
    logic tmout;
    logic enb;
    logic alloc;
  } flags_t;

endpackage

`default_nettype wire

@@ design/countdown_timer_bank.sv @@
// Countdown timer bank: sixteen timers under a command sequencer.
//
// Commands arrive on the input channel (command_i, timer_index_i,
// count_value_i, auto_mode_i) under in_valid_i/in_ready_o. Each command
// gives exactly one result transfer on the output channel (status_o and
// the addressed timer's state) under out_valid_o/out_ready_i.
// One command is worked on at a time; in_ready_o is high only while the
// sequencer is idle. Tick walks all timers through one shared
// decrement-and-compare unit, one timer per cycle. Allocate scans for the
// lowest free timer, one per cycle. All other commands pass through an
// apply step; bad-index or bank-full results go straight to the report
// step.
// The result sits in an output register; the next command is accepted
// while it waits. If the receiver still holds off when the following
// result is ready, the sequencer waits in its report step until the
// output register frees up.
// Reset clears all reload values, counts, flags and the allocation count;
// the bank is ready right after reset is released.
`default_nettype none
`include "countdown_timer_bank_defines.svh"

module countdown_timer_bank
  import ctb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CmdW-1:0]   command_i,
  input  wire logic [TidxW-1:0]  timer_index_i,
  input  wire logic [15:0]       count_value_i,
  input  wire logic              auto_mode_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [StatW-1:0]       status_o,
  output logic [TidxW-1:0]       given_index_o,
  output logic                   timed_out_o,
  output logic                   is_enabled_o,
  output logic                   is_allocated_o,
  output logic [RemW-1:0]        remaining_o,
  output logic [MaskW-1:0]       expired_mask_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StTick   = 5'b00010,
    StScan   = 5'b00100,
    StApply  = 5'b01000,
    StReport = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [IdxW-1:0]      ptr_q, ptr_d;
  logic [MaskW-1:0]     mask_q, mask_d;
  stat_e                stat_q, stat_d;
  logic [TotW-1:0]      total_q, total_d;

  cmd_e                 cmd_q;
  logic [TidxW-1:0]     idx_q;
  logic [CountWidth-1:0] cval_q;
  logic                 auto_q;

  logic [CountWidth-1:0] reload_q [NumTimers];
  logic [CountWidth-1:0] count_q  [NumTimers];
  flags_t                flags_q  [NumTimers];

  logic                  in_xfer;
  logic                  idx_ok;
  logic [IdxW-1:0]       addr;
  logic [CountWidth-1:0] cur_reload, cur_count, dec_count;
  flags_t                cur_flags;
  logic                  wr_en;
  logic [CountWidth-1:0] nxt_reload, nxt_count;
  flags_t                nxt_flags;

  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic [StatW-1:0]      status_q;
  logic [TidxW-1:0]      given_q;
  logic                  tmout_q, enb_q, alloc_q;
  logic [RemW-1:0]       remaining_q;
  logic [MaskW-1:0]      exp_mask_q;

  logic [NumTimers-1:0]  alloc_vec, enb_vec;

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign idx_ok     = (32'(idx_q) < NumTimers);

  always_comb begin
    case (state_q)
      StTick, StScan: addr = ptr_q;
      StReport:       addr = (cmd_q == CmdAlloc) ? ptr_q : idx_q[IdxW-1:0];
      default:        addr = idx_q[IdxW-1:0];
    endcase
  end

  assign cur_reload = reload_q[addr];
  assign cur_count  = count_q[addr];
  assign cur_flags  = flags_q[addr];
  assign dec_count  = cur_count - CountWidth'(1);

  always_comb begin
    for (int i = 0; i < NumTimers; i++) begin
      alloc_vec[i] = flags_q[i].alloc;
      enb_vec[i]   = flags_q[i].enb;
    end
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    mask_d     = mask_q;
    stat_d     = stat_q;
    total_d    = total_q;
    wr_en      = 1'b0;
    nxt_reload = cur_reload;
    nxt_count  = cur_count;
    nxt_flags  = cur_flags;
    out_load   = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ptr_d  = '0;
          mask_d = '0;
          stat_d = StatOk;
          case (cmd_e'(command_i))
            CmdTick: state_d = StTick;
            CmdAlloc: begin
              if (total_q >= TotW'(NumTimers)) begin
                stat_d  = StatNoFree;
                state_d = StReport;
              end else begin
                state_d = StScan;
              end
            end
            default: begin
              if (32'(timer_index_i) < NumTimers) begin
                state_d = StApply;
              end else begin
                stat_d  = StatBadIdx;
                state_d = StReport;
              end
            end
          endcase
        end
      end

      StTick: begin
        if (cur_flags.alloc && cur_flags.enb && (cur_count != '0)) begin
          wr_en     = 1'b1;
          nxt_count = dec_count;
          if (dec_count == '0) begin
            if (cur_flags.auto_mode) begin
              nxt_count = cur_reload;
            end else begin
              nxt_flags.enb = 1'b0;
            end
            nxt_flags.tmout = 1'b1;
            mask_d = mask_q | (MaskW'(1) << ptr_q);
          end
        end
        if (ptr_q == IdxW'(NumTimers - 1)) begin
          state_d = StReport;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end

      StScan: begin
        if (!cur_flags.alloc) begin
          wr_en           = 1'b1;
          nxt_flags.alloc = 1'b1;
          total_d         = total_q + TotW'(1);
          state_d         = StReport;
        end else if (ptr_q == IdxW'(NumTimers - 1)) begin
          stat_d  = StatNoFree;
          state_d = StReport;
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end

      StApply: begin
        wr_en   = 1'b1;
        state_d = StReport;
        case (cmd_q)
          CmdFree: begin
            if (cur_flags.alloc && (total_q != '0)) begin
              total_d = total_q - TotW'(1);
            end
            nxt_flags.enb   = 1'b0;
            nxt_flags.alloc = 1'b0;
          end
          CmdStart: begin
            if (cur_flags.alloc) begin
              nxt_flags.tmout = 1'b0;
              nxt_count       = cur_reload;
              nxt_flags.enb   = (cur_reload != '0);
            end
          end
          CmdStop: nxt_flags.enb = 1'b0;
          CmdLoadStart: begin
            nxt_reload          = cval_q;
            nxt_count           = cval_q;
            nxt_flags.auto_mode = auto_q;
            if (cur_flags.alloc) begin
              nxt_flags.tmout = 1'b0;
              nxt_flags.enb   = (cval_q != '0);
            end
          end
          CmdClrTmout: nxt_flags.tmout = 1'b0;
          default: wr_en = 1'b0;
        endcase
      end

      StReport: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ptr_q       <= '0;
      mask_q      <= '0;
      stat_q      <= StatOk;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumTimers; i++) begin
        reload_q[i] <= '0;
        count_q[i]  <= '0;
        flags_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      mask_q      <= mask_d;
      stat_q      <= stat_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (wr_en) begin
        reload_q[addr] <= nxt_reload;
        count_q[addr]  <= nxt_count;
        flags_q[addr]  <= nxt_flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= cmd_e'(command_i);
      idx_q  <= timer_index_i;
      cval_q <= CountWidth'(count_value_i);
      auto_q <= auto_mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q   <= stat_q;
      exp_mask_q <= (stat_q == StatOk) ? mask_q : '0;
      if (stat_q == StatOk && idx_ok) begin
        given_q     <= (cmd_q == CmdAlloc) ? TidxW'(ptr_q) : '0;
        tmout_q     <= cur_flags.tmout;
        enb_q       <= cur_flags.enb;
        alloc_q     <= cur_flags.alloc;
        remaining_q <= RemW'(cur_count);
      end else begin
        given_q     <= '0;
        tmout_q     <= 1'b0;
        enb_q       <= 1'b0;
        alloc_q     <= 1'b0;
        remaining_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign given_index_o  = given_q;
  assign timed_out_o    = tmout_q;
  assign is_enabled_o   = enb_q;
  assign is_allocated_o = alloc_q;
  assign remaining_o    = remaining_q;
  assign expired_mask_o = exp_mask_q;

  `CTB_ASSERT(a_total_bound, clk_i, rst_ni, total_q <= TotW'(NumTimers))
  `CTB_ASSERT(a_total_matches, clk_i, rst_ni, $countones(alloc_vec) == 32'(total_q))
  `CTB_ASSERT(a_enb_needs_alloc, clk_i, rst_ni, (enb_vec & ~alloc_vec) == '0)
  `CTB_ASSERT(a_tick_ends, clk_i, rst_ni, (state_q == StTick) && (ptr_q == IdxW'(NumTimers - 1)) |=> (state_q == StReport))
  `CTB_ASSERT(a_tick_starts, clk_i, rst_ni, in_xfer && (command_i == CmdTick) |=> (state_q == StTick) && (mask_q == '0))

endmodule

`default_nettype wire

@@ verif/countdown_timer_bank_checker.sv @@
// Checker for the countdown timer bank: predicts every command's result and compares transfers.
`default_nettype none

module countdown_timer_bank_checker
  import ctb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic [CmdW-1:0]  command_i,
  input  wire logic [TidxW-1:0] timer_index_i,
  input  wire logic [15:0]      count_value_i,
  input  wire logic             auto_mode_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic [StatW-1:0] status_i,
  input  wire logic [TidxW-1:0] given_index_i,
  input  wire logic             timed_out_i,
  input  wire logic             is_enabled_i,
  input  wire logic             is_allocated_i,
  input  wire logic [RemW-1:0]  remaining_i,
  input  wire logic [MaskW-1:0] expired_mask_i,
  input  wire logic             end_check_i,
  output int unsigned           fail_count_o,
  output int unsigned           outstanding_o
);

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [TidxW-1:0] given_index;
    logic             timed_out;
    logic             is_enabled;
    logic             is_allocated;
    logic [RemW-1:0]  remaining;
    logic [MaskW-1:0] expired_mask;
  } timer_result_t;

  logic [CountWidth-1:0] reload_q [NumTimers];
  logic [CountWidth-1:0] count_q  [NumTimers];
  flags_t                flags_q  [NumTimers];
  logic [TotW-1:0]       alloc_total_q;
  timer_result_t         pending_results [$];
  bit                    end_done;

  task automatic log_failure(input string msg);
    $display("[%0t] countdown_timer_bank mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned exp);
    if (got != exp) begin
      log_failure($sformatf("%s got 0x%0h, expected 0x%0h", name, got, exp));
    end
  endtask

  function automatic timer_result_t timer_view(input int t, input timer_result_t base);
    base.timed_out    = flags_q[t].tmout;
    base.is_enabled   = flags_q[t].enb;
    base.is_allocated = flags_q[t].alloc;
    base.remaining    = RemW'(count_q[t]);
    return base;
  endfunction

  task automatic start_timer(input int t);
    if (!flags_q[t].alloc) return;
    flags_q[t].tmout = 1'b0;
    count_q[t]       = reload_q[t];
    flags_q[t].enb   = (reload_q[t] != '0);
  endtask

  task automatic predict_command(input cmd_e cmd, input logic [TidxW-1:0] idx,
                                 input logic [15:0] cval, input logic am,
                                 output timer_result_t res);
    int t;
    int i;
    int slot;
    t    = int'(idx);
    slot = -1;
    res  = '0;
    case (cmd)
      CmdTick: begin
        for (i = 0; i < NumTimers; i++) begin
          if (flags_q[i].alloc && flags_q[i].enb && count_q[i] != '0) begin
            count_q[i] = count_q[i] - 1'b1;
            if (count_q[i] == '0) begin
              if (flags_q[i].auto_mode) count_q[i] = reload_q[i];
              else flags_q[i].enb = 1'b0;
              flags_q[i].tmout = 1'b1;
              if (i < MaskW) res.expired_mask[i] = 1'b1;
            end
          end
        end
        if (t < NumTimers) res = timer_view(t, res);
      end
      CmdAlloc: begin
        if (alloc_total_q < NumTimers) begin
          for (i = 0; i < NumTimers; i++) begin
            if (slot < 0 && !flags_q[i].alloc) slot = i;
          end
        end
        if (slot < 0) begin
          res.status = StatNoFree;
        end else begin
          flags_q[slot].alloc = 1'b1;
          alloc_total_q       = alloc_total_q + 1'b1;
          res.given_index     = TidxW'(slot);
          res                 = timer_view(slot, res);
        end
      end
      default: begin
        if (t >= NumTimers) begin
          res.status = StatBadIdx;
        end else begin
          case (cmd)
            CmdFree: begin
              if (flags_q[t].alloc && alloc_total_q != '0) alloc_total_q = alloc_total_q - 1'b1;
              flags_q[t].enb   = 1'b0;
              flags_q[t].alloc = 1'b0;
            end
            CmdStart: start_timer(t);
            CmdStop: flags_q[t].enb = 1'b0;
            CmdLoadStart: begin
              reload_q[t]          = CountWidth'(cval);
              count_q[t]           = CountWidth'(cval);
              flags_q[t].auto_mode = am;
              start_timer(t);
            end
            CmdClrTmout: flags_q[t].tmout = 1'b0;
            default: ;
          endcase
          res = timer_view(t, res);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    timer_result_t got;
    timer_result_t exp;
    if (!rst_ni) begin
      for (int i = 0; i < NumTimers; i++) begin
        reload_q[i] = '0;
        count_q[i]  = '0;
        flags_q[i]  = '0;
      end
      alloc_total_q = '0;
      pending_results.delete();
      fail_count_o  = 0;
      end_done      = 1'b0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          log_failure("result transfer with nothing expected");
        end else begin
          exp = pending_results.pop_front();
          got = '{status_i, given_index_i, timed_out_i, is_enabled_i, is_allocated_i,
                  remaining_i, expired_mask_i};
          check_field("status", got.status, exp.status);
          check_field("given_index", got.given_index, exp.given_index);
          check_field("timed_out", got.timed_out, exp.timed_out);
          check_field("is_enabled", got.is_enabled, exp.is_enabled);
          check_field("is_allocated", got.is_allocated, exp.is_allocated);
          check_field("remaining", got.remaining, exp.remaining);
          check_field("expired_mask", got.expired_mask, exp.expired_mask);
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_command(cmd_e'(command_i), timer_index_i, count_value_i, auto_mode_i, exp);
        pending_results.push_back(exp);
      end
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (pending_results.size() != 0) begin
          log_failure($sformatf("%0d expected results never arrived", pending_results.size()));
        end
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_countdown_timer_bank.sv @@
// Testbench top for the countdown timer bank: clock, reset, command stimulus and verdict.
`default_nettype none

module tb_countdown_timer_bank;
  import ctb_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 400;
  localparam int MaxGap     = 40;
  localparam int DrainWait  = 40;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CmdW-1:0]  command_i;
  logic [TidxW-1:0] timer_index_i;
  logic [15:0]      count_value_i;
  logic             auto_mode_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [StatW-1:0] status_o;
  logic [TidxW-1:0] given_index_o;
  logic             timed_out_o;
  logic             is_enabled_o;
  logic             is_allocated_o;
  logic [RemW-1:0]  remaining_o;
  logic [MaskW-1:0] expired_mask_o;
  logic             end_check;
  int unsigned      fail_count;
  int unsigned      outstanding;

  int idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_served;
  int cycle_count;

  always #5 clk_i = ~clk_i;

  countdown_timer_bank DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .timer_index_i  (timer_index_i),
    .count_value_i  (count_value_i),
    .auto_mode_i    (auto_mode_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .given_index_o  (given_index_o),
    .timed_out_o    (timed_out_o),
    .is_enabled_o   (is_enabled_o),
    .is_allocated_o (is_allocated_o),
    .remaining_o    (remaining_o),
    .expired_mask_o (expired_mask_o)
  );

  countdown_timer_bank_checker timer_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .timer_index_i  (timer_index_i),
    .count_value_i  (count_value_i),
    .auto_mode_i    (auto_mode_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .given_index_i  (given_index_o),
    .timed_out_i    (timed_out_o),
    .is_enabled_i   (is_enabled_o),
    .is_allocated_i (is_allocated_o),
    .remaining_i    (remaining_o),
    .expired_mask_i (expired_mask_o),
    .end_check_i    (end_check),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_ready_i  = 1'b0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[countdown_timer_bank] ERROR");
    $finish;
  end

  task automatic send_command(input cmd_e cmd, input logic [TidxW-1:0] idx,
                              input logic [15:0] cval, input logic am);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    timer_index_i <= idx;
    count_value_i <= cval;
    auto_mode_i   <= am;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_items,
                           input bit with_hold);
    int k;
    int r;
    cmd_e cmd;
    logic [15:0] cval;
    idle_pct  = idle;
    stall_pct <= stall;
    for (k = 0; k < n_items; k++) begin
      if (with_hold && k == 40) hold_requests <= hold_requests + 1;
      r = $urandom_range(99);
      if      (r < 30) cmd = CmdTick;
      else if (r < 42) cmd = CmdAlloc;
      else if (r < 48) cmd = CmdFree;
      else if (r < 56) cmd = CmdStart;
      else if (r < 62) cmd = CmdStop;
      else if (r < 78) cmd = CmdLoadStart;
      else if (r < 84) cmd = CmdClrTmout;
      else             cmd = CmdRead;
      r = $urandom_range(9);
      if      (r < 6)  cval = 16'($urandom_range(6));
      else if (r == 6) cval = 16'h0000;
      else if (r == 7) cval = 16'hFFFF;
      else             cval = 16'($urandom);
      send_command(cmd,
                   $urandom_range(1) ? TidxW'($urandom_range(3)) : TidxW'($urandom_range(15)),
                   cval, 1'($urandom_range(1)));
    end
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = '0;
    timer_index_i = '0;
    count_value_i = '0;
    auto_mode_i   = 1'b0;
    end_check     = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the bank, then one allocate too many
    for (int k = 0; k <= NumTimers; k++) send_command(CmdAlloc, TidxW'(k), 16'h0000, 1'b0);
    send_command(CmdLoadStart, 4'd0, 16'd2, 1'b1);
    send_command(CmdLoadStart, 4'd1, 16'd1, 1'b0);
    send_command(CmdTick, 4'd15, 16'hFFFF, 1'b1);
    send_command(CmdTick, 4'd0, 16'h0000, 1'b0);
    send_command(CmdClrTmout, 4'd0, 16'h0000, 1'b0);
    send_command(CmdStop, 4'd0, 16'h0000, 1'b0);
    send_command(CmdStart, 4'd0, 16'h0000, 1'b0);
    send_command(CmdFree, 4'd5, 16'h0000, 1'b0);
    send_command(CmdFree, 4'd5, 16'h0000, 1'b0);
    // load and start on a free timer: values land, start is skipped
    send_command(CmdLoadStart, 4'd5, 16'hFFFF, 1'b1);
    send_command(CmdStart, 4'd5, 16'h0000, 1'b0);
    send_command(CmdRead, 4'd15, 16'h0000, 1'b0);
    send_command(CmdLoadStart, 4'd1, 16'h0000, 1'b1);
    in_valid_i <= 1'b0;
    wait_drained();

    run_phase(0, 0, 320, 1'b1);
    run_phase(76, 0, 310, 1'b0);
    run_phase(0, 76, 310, 1'b0);
    run_phase(20, 20, 310, 1'b0);

    repeat (DrainWait) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[countdown_timer_bank] OK");
    end else begin
      $display("[countdown_timer_bank] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
